// ===== hw/rtl/sqe_pkg.sv =====
// Shared types, constants and a helper function of the stack and queue engine.
package sqe_pkg;

  // Store geometry.
  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int DATA_W = 32;

  // Configuration port geometry: one 32-bit register at byte address zero.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic CFG_IDX_QUEUE_MODE = 1'b0;

  // Operation codes carried on the input channel.
  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_DUMP = 3'd1,
    OP_PEEK = 3'd2,
    OP_POP  = 3'd3,
    OP_SWAP = 3'd4
  } op_t;

  // Status codes carried on the result channel.
  typedef enum logic [2:0] {
    ST_DATA       = 3'd0,
    ST_PEEK_EMPTY = 3'd1,
    ST_POP_EMPTY  = 3'd2,
    ST_SWAP_SHORT = 3'd3,
    ST_PUSH_FULL  = 3'd4
  } status_t;

  // One result transaction.
  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    status_t                  status;
    logic                     last;
  } res_t;

  // Result hand-over from the sequencer to the output buffer.
  typedef struct packed {
    logic valid;
    res_t res;
  } res_push_t;

  // Output buffer state reported back to the sequencer.
  typedef struct packed {
    logic [1:0] fill;
    logic       pop;
  } fifo_stat_t;

  // Ring index plus an offset, wrapped into the store. The offset is below DEPTH.
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = {{(SUM_W - IDX_W){1'b0}}, a} + {1'b0, b};
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/sqe_if.sv =====
// Valid/ready channel interfaces for the input and result transactions.
interface sqe_in_if;
  logic                              valid;
  logic                              ready;
  logic [2:0]                        op;
  logic signed [sqe_pkg::DATA_W-1:0] push_value;

  modport source (output valid, output op, output push_value, input ready);
  modport sink (input valid, input op, input push_value, output ready);
endinterface

interface sqe_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [sqe_pkg::DATA_W-1:0] data;
  logic [2:0]                        status;
  logic                              last;

  modport source (output valid, output data, output status, output last, input ready);
  modport sink (input valid, input data, input status, input last, output ready);
endinterface

// ===== hw/rtl/sqe_cfg.sv =====
// APB-style configuration register block holding the queue mode bit.
module sqe_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sqe_pkg::CFG_AW-1:0] paddr,
  input  logic [sqe_pkg::CFG_DW-1:0] pwdata,
  output logic [sqe_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output logic                       queue_mode_o
);

  logic queue_mode_r;
  logic sel_queue_mode;

  // Register decode uses the word index bit only.
  assign sel_queue_mode = (paddr[sqe_pkg::CFG_AW-1] == sqe_pkg::CFG_IDX_QUEUE_MODE);
  assign pready = 1'b1;

  // Write on the access phase of a write transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_mode_r <= 1'b0;
    end else if (psel && penable && pwrite && pready && sel_queue_mode) begin
      queue_mode_r <= pwdata[0];
    end
  end

  // Read back the register value; unmapped addresses read as zero.
  assign prdata = sel_queue_mode ? {{(sqe_pkg::CFG_DW - 1){1'b0}}, queue_mode_r}
                                 : '0;
  assign queue_mode_o = queue_mode_r;

endmodule

// ===== hw/rtl/sqe_out_fifo.sv =====
// Two-entry result buffer between the sequencer and the result channel.
module sqe_out_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sqe_pkg::res_push_t     push_i,
  output sqe_pkg::fifo_stat_t    stat_o,
  sqe_out_if.source              out_ch
);

  sqe_pkg::res_t ent_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    fill_r;
  logic          pop;

  assign pop = out_ch.valid && out_ch.ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      fill_r <= fill_r + {1'b0, push_i.valid} - {1'b0, pop};
    end
  end

  // Entry storage carries payload only.
  always_ff @(posedge clk) begin
    if (push_i.valid) begin
      ent_r[wr_ptr_r] <= push_i.res;
    end
  end

  assign out_ch.valid  = (fill_r != 2'd0);
  assign out_ch.data   = ent_r[rd_ptr_r].data;
  assign out_ch.status = ent_r[rd_ptr_r].status;
  assign out_ch.last   = ent_r[rd_ptr_r].last;

  assign stat_o.fill = fill_r;
  assign stat_o.pop  = pop;

endmodule

// ===== hw/rtl/sqe_core.sv =====
// Operation sequencer around the one-write, one-read entry memory of the ring buffer.
module sqe_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    queue_mode_i,
  input  sqe_pkg::fifo_stat_t     fifo_st_i,
  output sqe_pkg::res_push_t      push_o,
  sqe_in_if.sink                  in_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STREAM,
    S_SWAP_RD1,
    S_SWAP_RD2,
    S_SWAP_WR
  } state_t;

  localparam logic [sqe_pkg::CNT_W-1:0] CNT_FULL = sqe_pkg::CNT_W'(sqe_pkg::DEPTH);
  localparam logic [sqe_pkg::CNT_W-1:0] CNT_ONE  = sqe_pkg::CNT_W'(1);
  localparam logic [sqe_pkg::CNT_W-1:0] CNT_TWO  = sqe_pkg::CNT_W'(2);
  localparam logic [sqe_pkg::CNT_W-1:0] CNT_BACK = sqe_pkg::CNT_W'(sqe_pkg::DEPTH - 1);

  // Entry memory.
  logic signed [sqe_pkg::DATA_W-1:0] mem [sqe_pkg::DEPTH];
  logic signed [sqe_pkg::DATA_W-1:0] rdata_r;
  logic                              we;
  logic [sqe_pkg::IDX_W-1:0]         waddr;
  logic signed [sqe_pkg::DATA_W-1:0] wdata;
  logic                              re;
  logic [sqe_pkg::IDX_W-1:0]         raddr;

  // Control state.
  state_t                            state_r, state_nxt;
  logic [sqe_pkg::IDX_W-1:0]         top_r, top_nxt;
  logic [sqe_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [sqe_pkg::CNT_W-1:0]         idx_r, idx_nxt;
  logic                              pend_r, pend_nxt;
  logic                              pend_last_r, pend_last_nxt;

  // Swap scratch, payload only.
  logic [sqe_pkg::IDX_W-1:0]         s1_r, s1_nxt;
  logic signed [sqe_pkg::DATA_W-1:0] tmp_r, tmp_nxt;

  logic                              acc;
  logic [1:0]                        occ;
  logic                              can_issue;

  assign in_ch.ready = (state_r == S_IDLE) && (fifo_st_i.fill != 2'd2);
  assign acc = in_ch.valid && in_ch.ready;

  // Buffer slots already promised: entries held plus a read whose data lands next cycle.
  assign occ = fifo_st_i.fill + {1'b0, pend_r};
  assign can_issue = (idx_r < cnt_r) && ((occ <= 2'd1) || ((occ == 2'd2) && fifo_st_i.pop));

  // Sequencer next-state and memory access decode.
  always_comb begin
    state_nxt     = state_r;
    top_nxt       = top_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    pend_last_nxt = pend_last_r;
    s1_nxt        = s1_r;
    tmp_nxt       = tmp_r;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    re            = 1'b0;
    raddr         = '0;
    push_o        = '0;

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_ch.op)
            sqe_pkg::OP_PUSH: begin
              if (cnt_r >= CNT_FULL) begin
                push_o.valid      = 1'b1;
                push_o.res.status = sqe_pkg::ST_PUSH_FULL;
                push_o.res.last   = 1'b1;
              end else begin
                we    = 1'b1;
                wdata = in_ch.push_value;
                if (queue_mode_i) begin
                  waddr = sqe_pkg::wrap_add(top_r, cnt_r);
                end else begin
                  waddr   = sqe_pkg::wrap_add(top_r, CNT_BACK);
                  top_nxt = waddr;
                end
                cnt_nxt = cnt_r + CNT_ONE;
              end
            end
            sqe_pkg::OP_DUMP: begin
              if (cnt_r != '0) begin
                re            = 1'b1;
                raddr         = top_r;
                idx_nxt       = CNT_ONE;
                pend_nxt      = 1'b1;
                pend_last_nxt = (cnt_r == CNT_ONE);
                state_nxt     = S_STREAM;
              end
            end
            sqe_pkg::OP_PEEK: begin
              if (cnt_r == '0) begin
                push_o.valid      = 1'b1;
                push_o.res.status = sqe_pkg::ST_PEEK_EMPTY;
                push_o.res.last   = 1'b1;
              end else begin
                // A peek is a stream of one read with nothing left to issue.
                re            = 1'b1;
                raddr         = top_r;
                idx_nxt       = cnt_r;
                pend_nxt      = 1'b1;
                pend_last_nxt = 1'b1;
                state_nxt     = S_STREAM;
              end
            end
            sqe_pkg::OP_POP: begin
              if (cnt_r == '0) begin
                push_o.valid      = 1'b1;
                push_o.res.status = sqe_pkg::ST_POP_EMPTY;
                push_o.res.last   = 1'b1;
              end else begin
                top_nxt = sqe_pkg::wrap_add(top_r, CNT_ONE);
                cnt_nxt = cnt_r - CNT_ONE;
              end
            end
            sqe_pkg::OP_SWAP: begin
              if (cnt_r < CNT_TWO) begin
                push_o.valid      = 1'b1;
                push_o.res.status = sqe_pkg::ST_SWAP_SHORT;
                push_o.res.last   = 1'b1;
              end else begin
                re        = 1'b1;
                raddr     = top_r;
                s1_nxt    = sqe_pkg::wrap_add(top_r, CNT_ONE);
                state_nxt = S_SWAP_RD1;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Dump and peek: forward each returned entry and keep reads flowing.
      S_STREAM: begin
        if (pend_r) begin
          push_o.valid      = 1'b1;
          push_o.res.data   = rdata_r;
          push_o.res.status = sqe_pkg::ST_DATA;
          push_o.res.last   = pend_last_r;
        end
        if (can_issue) begin
          re            = 1'b1;
          raddr         = sqe_pkg::wrap_add(top_r, idx_r);
          idx_nxt       = idx_r + CNT_ONE;
          pend_nxt      = 1'b1;
          pend_last_nxt = (idx_r == (cnt_r - CNT_ONE));
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r && pend_last_r) begin
          pend_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end

      // Swap: read both entries, then write each back into the other's slot.
      S_SWAP_RD1: begin
        re        = 1'b1;
        raddr     = s1_r;
        tmp_nxt   = rdata_r;
        state_nxt = S_SWAP_RD2;
      end
      S_SWAP_RD2: begin
        we        = 1'b1;
        waddr     = top_r;
        wdata     = rdata_r;
        state_nxt = S_SWAP_WR;
      end
      S_SWAP_WR: begin
        we        = 1'b1;
        waddr     = s1_r;
        wdata     = tmp_r;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      pend_last_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      pend_last_r <= pend_last_nxt;
    end
  end

  // Swap scratch registers.
  always_ff @(posedge clk) begin
    s1_r  <= s1_nxt;
    tmp_r <= tmp_nxt;
  end

  // Synchronous memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  // The entry count never passes the store depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("entry count beyond store depth");

  // While streaming, the position never runs past the stored entries.
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STREAM) |-> (idx_r <= cnt_r))
    else $error("stream index beyond entry count");

  // A result is only handed over when the output buffer has room for it.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_o.valid |-> ((fifo_st_i.fill < 2'd2) || fifo_st_i.pop))
    else $error("result buffer overflow");

  // A successful pop removes exactly one entry.
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_ch.op == sqe_pkg::OP_POP) && (cnt_r != '0))
      |=> (cnt_r == ($past(cnt_r) - CNT_ONE)))
    else $error("pop did not reduce the entry count by one");

endmodule

// ===== hw/rtl/stack_queue_engine_top.sv =====
// Top level of the stack and queue engine: configuration, sequencer and result buffer.
//
// The engine keeps up to 64 signed 32-bit values in a ring buffer held in one
// synchronous memory with one write port and one registered read port, so every
// item is served by a short walk of the sequencer around that memory. A push, a pop
// and any error result are handled in the idle state; a peek reads, then delivers; a
// swap of the top two entries makes two reads, then two writes; a dump of n entries
// makes one memory read per entry. No new transaction is accepted until the current
// one has finished in the sequencer, but a two-entry result buffer lets the next
// transaction start while earlier results still wait. The queue mode bit (register 0,
// byte address 0) selects whether a push goes to the top or the bottom, and should be
// written only while the engine is idle. Reading an entry always follows a write of
// it, so the memory needs no clearing after reset.
module stack_queue_engine_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sqe_pkg::CFG_AW-1:0] paddr,
  input  logic [sqe_pkg::CFG_DW-1:0] pwdata,
  output logic [sqe_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  sqe_in_if.sink                     in_chan,
  sqe_out_if.source                  out_chan
);

  logic                queue_mode;
  sqe_pkg::res_push_t  res_push;
  sqe_pkg::fifo_stat_t fifo_st;

  // Configuration registers.
  sqe_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .queue_mode_o (queue_mode)
  );

  // Sequencer and entry memory.
  sqe_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .queue_mode_i (queue_mode),
    .fifo_st_i    (fifo_st),
    .push_o       (res_push),
    .in_ch        (in_chan)
  );

  // Result buffer feeding the result channel.
  sqe_out_fifo u_out_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (res_push),
    .stat_o (fifo_st),
    .out_ch (out_chan)
  );

endmodule
